@@ rtl/quadratic_root_solver_unit_defines.svh @@
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrs check failed");
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrs check failed");
`else
`define QRS_ASSERT_IMPLY(lbl, ante, cons)
`define QRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/qrs_pkg.sv @@
`default_nettype none
package qrs_pkg;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    KIND_DOUBLE   = 2'd0,
    KIND_TWO_REAL = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_INVALID  = 2'd3
  } kind_t;
endpackage
`default_nettype wire

@@ rtl/qrs_if.sv @@
`default_nettype none
interface qrs_in_if #(parameter int W = qrs_pkg::DATA_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coef_a;
  logic signed [W-1:0] coef_b;
  logic signed [W-1:0] coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if #(parameter int W = qrs_pkg::DATA_WIDTH_DEF);
  logic                valid;
  logic                ready;
  qrs_pkg::kind_t      root_kind;
  logic signed [W-1:0] root_one_real;
  logic signed [W-1:0] root_two_real;
  logic signed [W-1:0] imag_part;
  logic                saturated;
  modport source (output valid, root_kind, root_one_real, root_two_real, imag_part,
                  saturated, input ready);
  modport sink   (input valid, root_kind, root_one_real, root_two_real, imag_part,
                  saturated, output ready);
endinterface
`default_nettype wire

@@ rtl/qrs_disc.sv @@
`default_nettype none
// magnitudes, products and discriminant, three stages
module qrs_disc #(
  parameter int W = qrs_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic signed [W-1:0] in_a,
  input  wire logic signed [W-1:0] in_b,
  input  wire logic signed [W-1:0] in_c,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [2*W:0]        out_rad,
  output      logic                out_d_neg,
  output      logic                out_a_zero,
  output      logic                out_a_neg,
  output      logic signed [W-1:0] out_b,
  output      logic [W:0]          out_den
);
  localparam int DW = 2*W+1;

  logic adv1, adv2, adv3;
  // stage 1
  logic                v1_r, an1_r, cn1_r, az1_r, cz1_r;
  logic [W-1:0]        am1_r, bm1_r, cm1_r;
  logic signed [W-1:0] b1_r;
  logic [W-1:0]        am_nxt, bm_nxt, cm_nxt;
  // stage 2
  logic                v2_r, an2_r, az2_r, opp2_r;
  logic [2*W-1:0]      bb2_r, ac2_r;
  logic [W-1:0]        am2_r;
  logic signed [W-1:0] b2_r;
  // stage 3
  logic                v3_r, dn3_r, az3_r, an3_r;
  logic [DW-1:0]       d3_r;
  logic signed [W-1:0] b3_r;
  logic [W:0]          den3_r;
  logic [DW-1:0]       bbx, ac4, d_nxt;
  logic                ge, dn_nxt;

  assign adv3     = ~v3_r | out_ready;
  assign adv2     = ~v2_r | adv3;
  assign adv1     = ~v1_r | adv2;
  assign in_ready = adv1;

  assign am_nxt = in_a[W-1] ? (~in_a + 1'b1) : in_a;
  assign bm_nxt = in_b[W-1] ? (~in_b + 1'b1) : in_b;
  assign cm_nxt = in_c[W-1] ? (~in_c + 1'b1) : in_c;

  // |a*c| is at most 2^(2W-2), so 4ac fits DW bits
  assign bbx = {1'b0, bb2_r};
  assign ac4 = {ac2_r[2*W-2:0], 2'b00};
  assign ge  = bbx >= ac4;
  always_comb begin
    if (opp2_r) d_nxt = bbx + ac4;
    else if (ge) d_nxt = bbx - ac4;
    else d_nxt = ac4 - bbx;
  end
  assign dn_nxt = ~opp2_r & ~ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
    if (adv1) begin
      am1_r <= am_nxt;
      bm1_r <= bm_nxt;
      cm1_r <= cm_nxt;
      an1_r <= in_a[W-1];
      cn1_r <= in_c[W-1];
      az1_r <= in_a == '0;
      cz1_r <= in_c == '0;
      b1_r  <= in_b;
    end
    if (adv2) begin
      bb2_r  <= bm1_r * bm1_r;
      ac2_r  <= am1_r * cm1_r;
      opp2_r <= ~cz1_r & (an1_r ^ cn1_r);
      an2_r  <= an1_r;
      az2_r  <= az1_r;
      am2_r  <= am1_r;
      b2_r   <= b1_r;
    end
    if (adv3) begin
      d3_r   <= d_nxt;
      dn3_r  <= dn_nxt;
      az3_r  <= az2_r;
      an3_r  <= an2_r;
      b3_r   <= b2_r;
      den3_r <= {am2_r, 1'b0};
    end
  end

  assign out_valid  = v3_r;
  assign out_rad    = d3_r;
  assign out_d_neg  = dn3_r;
  assign out_a_zero = az3_r;
  assign out_a_neg  = an3_r;
  assign out_b      = b3_r;
  assign out_den    = den3_r;
endmodule
`default_nettype wire

@@ rtl/qrs_sqrt.sv @@
`default_nettype none
// floor square root, one result bit per stage
module qrs_sqrt #(
  parameter int RAD_W  = 2*qrs_pkg::DATA_WIDTH_DEF+1,
  parameter int SIDE_W = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [RAD_W-1:0]          in_rad,
  input  wire logic [SIDE_W-1:0]         in_side,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [(RAD_W+1)/2-1:0]    out_root,
  output      logic [SIDE_W-1:0]         out_side
);
  localparam int SW = (RAD_W+1)/2;
  localparam int PW = 2*SW;
  localparam int RW = SW+3;

  logic              v_r    [SW];
  logic [RW-1:0]     rem_r  [SW];
  logic [SW-1:0]     q_r    [SW];
  logic [PW-1:0]     d_r    [SW];
  logic [SIDE_W-1:0] side_r [SW];
  logic [SW:0]       adv;

  assign adv[SW]  = out_ready;
  assign in_ready = adv[0];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic              vin;
    logic [RW-1:0]     rem_in, cat, trial, rem_nxt;
    logic [SW-1:0]     q_in;
    logic [PW-1:0]     d_in;
    logic [SIDE_W-1:0] side_in;
    logic              ge;
    if (k == 0) begin : g_first
      assign vin     = in_valid;
      assign rem_in  = '0;
      assign q_in    = '0;
      assign d_in    = PW'(in_rad);
      assign side_in = in_side;
    end else begin : g_next
      assign vin     = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign d_in    = d_r[k-1];
      assign side_in = side_r[k-1];
    end
    assign cat     = {rem_in[RW-3:0], d_in[PW-1:PW-2]};
    assign trial   = RW'({q_in, 2'b01});
    assign ge      = cat >= trial;
    assign rem_nxt = ge ? cat - trial : cat;
    assign adv[k]  = ~v_r[k] | adv[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (adv[k]) v_r[k] <= vin;
      if (adv[k]) begin
        rem_r[k]  <= rem_nxt;
        q_r[k]    <= {q_in[SW-2:0], ge};
        d_r[k]    <= {d_in[PW-3:0], 2'b00};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[SW-1];
  assign out_root  = q_r[SW-1];
  assign out_side  = side_r[SW-1];
endmodule
`default_nettype wire

@@ rtl/qrs_div.sv @@
`default_nettype none
// two-lane restoring divider sharing one divisor, one quotient bit per stage
module qrs_div #(
  parameter int NUM_W  = qrs_pkg::DATA_WIDTH_DEF+3,
  parameter int DEN_W  = qrs_pkg::DATA_WIDTH_DEF+1,
  parameter int FRAC   = qrs_pkg::FRAC_BITS_DEF,
  parameter int SIDE_W = 2
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output      logic                    in_ready,
  input  wire logic signed [NUM_W-1:0] in_num1,
  input  wire logic signed [NUM_W-1:0] in_num2,
  input  wire logic [DEN_W-1:0]        in_den,
  input  wire logic                    in_den_neg,
  input  wire logic [SIDE_W-1:0]       in_side,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      logic [NUM_W+FRAC-1:0]   out_q1,
  output      logic [NUM_W+FRAC-1:0]   out_q2,
  output      logic                    out_neg1,
  output      logic                    out_neg2,
  output      logic [SIDE_W-1:0]       out_side
);
  localparam int QW = NUM_W + FRAC;

  logic              v_r    [QW+1];
  logic [DEN_W-1:0]  den_r  [QW+1];
  logic [SIDE_W-1:0] side_r [QW+1];
  logic [DEN_W-1:0]  rem_r  [2][QW+1];
  logic [QW-1:0]     q_r    [2][QW+1];
  logic [QW-1:0]     dd_r   [2][QW+1];
  logic              neg_r  [2][QW+1];
  logic [QW+1:0]     adv;
  logic [NUM_W-1:0]  num    [2];

  assign num[0]    = in_num1;
  assign num[1]    = in_num2;
  assign adv[QW+1] = out_ready;
  assign in_ready  = adv[0];

  // stage 0: sign and magnitude
  assign adv[0] = ~v_r[0] | adv[1];
  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (adv[0]) v_r[0] <= in_valid;
    if (adv[0]) begin
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_prep
    logic [NUM_W-1:0] mag_nxt;
    assign mag_nxt = num[l][NUM_W-1] ? (~num[l] + 1'b1) : num[l];
    always_ff @(posedge clk) begin
      if (adv[0]) begin
        dd_r[l][0]  <= {mag_nxt, {FRAC{1'b0}}};
        rem_r[l][0] <= '0;
        q_r[l][0]   <= '0;
        neg_r[l][0] <= num[l][NUM_W-1] ^ in_den_neg;
      end
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    assign adv[k] = ~v_r[k] | adv[k+1];
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (adv[k]) v_r[k] <= v_r[k-1];
      if (adv[k]) begin
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DEN_W:0]   cat;
      logic [DEN_W-1:0] rem_nxt;
      logic             ge;
      assign cat     = {rem_r[l][k-1], dd_r[l][k-1][QW-1]};
      assign ge      = cat >= {1'b0, den_r[k-1]};
      assign rem_nxt = ge ? DEN_W'(cat - {1'b0, den_r[k-1]}) : DEN_W'(cat);
      always_ff @(posedge clk) begin
        if (adv[k]) begin
          rem_r[l][k] <= rem_nxt;
          q_r[l][k]   <= {q_r[l][k-1][QW-2:0], ge};
          dd_r[l][k]  <= {dd_r[l][k-1][QW-2:0], 1'b0};
          neg_r[l][k] <= neg_r[l][k-1];
        end
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_q1    = q_r[0][QW];
  assign out_q2    = q_r[1][QW];
  assign out_neg1  = neg_r[0][QW];
  assign out_neg2  = neg_r[1][QW];
  assign out_side  = side_r[QW];
endmodule
`default_nettype wire

@@ rtl/quadratic_root_solver_unit.sv @@
// quadratic root solver: coefficients a, b, c of a*x^2 + b*x + c in, roots out
// in_ch carries coef_a, coef_b, coef_c as signed fixed point with FRAC_BITS
// fraction bits; out_ch carries root_kind, both real parts, the imaginary part
// of the complex pair (root two takes its negation) and a clipping flag.
// both channels move a transaction when valid and ready are high together.
// a new transaction is taken every cycle while in_ch.ready is high; the block
// holds no state between items. from input to output register an item passes
// the discriminant stages, the square root stages, the numerator stage, the
// divider stages and the clipping stage.
// the square root and the divider settle one bit per stage, hence their depth.
// a stalled receiver freezes only the stages that hold data; empty stages ahead
// of it keep filling, so in_ch.ready stays high until every stage is full.
// synchronous reset empties all stages; nothing is shown on out_ch after reset.
// a zero coefficient a gives kind invalid and all other fields zero.
`default_nettype none
`include "quadratic_root_solver_unit_defines.svh"
module quadratic_root_solver_unit #(
  parameter int DATA_WIDTH = qrs_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qrs_in_if.sink     in_ch,
  qrs_out_if.source  out_ch
);
  localparam int W      = DATA_WIDTH;
  localparam int RAD_W  = 2*W+1;
  localparam int SQ_W   = (RAD_W+1)/2;
  localparam int SIDE_W = 2*W+4;
  localparam int NUM_W  = W+3;
  localparam int DEN_W  = W+1;
  localparam int QW     = NUM_W+FRAC_BITS;
  localparam logic [QW-1:0] LIM = {{(QW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  // clip a quotient magnitude with its sign to the output range, {sat, value}
  function automatic logic [W:0] clip(input logic [QW-1:0] q, input logic neg);
    logic [W:0] res;
    if (neg) begin
      if (q > LIM) res = {1'b1, 1'b1, {(W-1){1'b0}}};
      else res = {1'b0, ~q[W-1:0] + 1'b1};
    end else begin
      if (q > LIM - 1'b1) res = {1'b1, 1'b0, {(W-1){1'b1}}};
      else res = {1'b0, q[W-1:0]};
    end
    return res;
  endfunction

  // discriminant stages
  logic                d_valid, d_ready, d_dneg, d_az, d_an;
  logic [RAD_W-1:0]    d_rad;
  logic signed [W-1:0] d_b;
  logic [DEN_W-1:0]    d_den;

  qrs_disc #(.W(W)) u_disc (
    .clk, .rst_n,
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_a      (in_ch.coef_a),
    .in_b      (in_ch.coef_b),
    .in_c      (in_ch.coef_c),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_rad   (d_rad),
    .out_d_neg (d_dneg),
    .out_a_zero(d_az),
    .out_a_neg (d_an),
    .out_b     (d_b),
    .out_den   (d_den)
  );

  // square root of |D|; the sign of D, the a flags, b and the divisor ride alongside
  logic              s_valid, s_ready;
  logic [SQ_W-1:0]   s_root;
  logic [SIDE_W-1:0] s_side;

  qrs_sqrt #(.RAD_W(RAD_W), .SIDE_W(SIDE_W)) u_sqrt (
    .clk, .rst_n,
    .in_valid (d_valid),
    .in_ready (d_ready),
    .in_rad   (d_rad),
    .in_side  ({d_az, d_an, d_dneg, d_b, d_den}),
    .out_valid(s_valid),
    .out_ready(s_ready),
    .out_root (s_root),
    .out_side (s_side)
  );

  // numerator stage: classify and form the two dividends
  logic                s_az, s_an, s_dneg;
  logic signed [W-1:0] s_b;
  logic [DEN_W-1:0]    s_den;
  logic signed [NUM_W-1:0] nb, sx, n1_nxt, n2_nxt;
  qrs_pkg::kind_t      kind_nxt;

  logic                    p_v_r, p_an_r, p_adv;
  logic signed [NUM_W-1:0] p_n1_r, p_n2_r;
  qrs_pkg::kind_t          p_kind_r;
  logic [DEN_W-1:0]        p_den_r;
  logic                    dv_ready;

  assign {s_az, s_an, s_dneg, s_b, s_den} = s_side;
  assign nb = -NUM_W'(s_b);
  assign sx = $signed(NUM_W'(s_root));

  always_comb begin
    // root of zero only when D is exactly zero
    if (s_az) kind_nxt = qrs_pkg::KIND_INVALID;
    else if (s_root == '0) kind_nxt = qrs_pkg::KIND_DOUBLE;
    else if (s_dneg) kind_nxt = qrs_pkg::KIND_COMPLEX;
    else kind_nxt = qrs_pkg::KIND_TWO_REAL;
  end

  always_comb begin
    n1_nxt = nb;
    n2_nxt = '0;
    case (kind_nxt)
      qrs_pkg::KIND_TWO_REAL: begin
        n1_nxt = nb + sx;
        n2_nxt = nb - sx;
      end
      qrs_pkg::KIND_COMPLEX: n2_nxt = sx;   // imaginary part goes in lane two
      default: n2_nxt = '0;
    endcase
  end

  assign p_adv   = ~p_v_r | dv_ready;
  assign s_ready = p_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) p_v_r <= 1'b0;
    else if (p_adv) p_v_r <= s_valid;
    if (p_adv) begin
      p_n1_r   <= n1_nxt;
      p_n2_r   <= n2_nxt;
      p_kind_r <= kind_nxt;
      p_an_r   <= s_an;
      p_den_r  <= s_den;
    end
  end

  // divide both lanes by 2|a|
  logic          dv_valid, dv_neg1, dv_neg2, o_adv;
  logic [QW-1:0] dv_q1, dv_q2;
  logic [1:0]    dv_side;

  qrs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .FRAC(FRAC_BITS), .SIDE_W(2)) u_div (
    .clk, .rst_n,
    .in_valid  (p_v_r),
    .in_ready  (dv_ready),
    .in_num1   (p_n1_r),
    .in_num2   (p_n2_r),
    .in_den    (p_den_r),
    .in_den_neg(p_an_r),
    .in_side   (p_kind_r),
    .out_valid (dv_valid),
    .out_ready (o_adv),
    .out_q1    (dv_q1),
    .out_q2    (dv_q2),
    .out_neg1  (dv_neg1),
    .out_neg2  (dv_neg2),
    .out_side  (dv_side)
  );

  // output register with clipping
  qrs_pkg::kind_t      dv_kind;
  logic [W:0]          c1, c2;
  logic signed [W-1:0] r1_nxt, r2_nxt, im_nxt;
  logic                sat_nxt;

  logic                o_v_r, o_sat_r;
  qrs_pkg::kind_t      o_kind_r;
  logic signed [W-1:0] o_r1_r, o_r2_r, o_im_r;

  assign dv_kind = qrs_pkg::kind_t'(dv_side);
  assign c1      = clip(dv_q1, dv_neg1);
  assign c2      = clip(dv_q2, dv_neg2);

  always_comb begin
    r1_nxt  = c1[W-1:0];
    r2_nxt  = c1[W-1:0];
    im_nxt  = '0;
    sat_nxt = c1[W];
    case (dv_kind)
      qrs_pkg::KIND_TWO_REAL: begin
        r2_nxt  = c2[W-1:0];
        sat_nxt = c1[W] | c2[W];
      end
      qrs_pkg::KIND_COMPLEX: begin
        im_nxt  = c2[W-1:0];
        sat_nxt = c1[W] | c2[W];
      end
      qrs_pkg::KIND_INVALID: begin
        r1_nxt  = '0;
        r2_nxt  = '0;
        sat_nxt = 1'b0;
      end
      default: sat_nxt = c1[W];
    endcase
  end

  assign o_adv = ~o_v_r | out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else if (o_adv) o_v_r <= dv_valid;
    if (o_adv) begin
      o_kind_r <= dv_kind;
      o_r1_r   <= r1_nxt;
      o_r2_r   <= r2_nxt;
      o_im_r   <= im_nxt;
      o_sat_r  <= sat_nxt;
    end
  end

  assign out_ch.valid         = o_v_r;
  assign out_ch.root_kind     = o_kind_r;
  assign out_ch.root_one_real = o_r1_r;
  assign out_ch.root_two_real = o_r2_r;
  assign out_ch.imag_part     = o_im_r;
  assign out_ch.saturated     = o_sat_r;

  // an invalid transaction carries only zeros
  `QRS_ASSERT_IMPLY(a_invalid_zero, o_v_r && o_kind_r == qrs_pkg::KIND_INVALID, o_r1_r == '0 && o_r2_r == '0 && o_im_r == '0 && !o_sat_r)
  // only a complex pair has an imaginary part
  `QRS_ASSERT_IMPLY(a_imag_complex, o_v_r && o_kind_r != qrs_pkg::KIND_COMPLEX, o_im_r == '0)
  // double roots and complex pairs share one real part
  `QRS_ASSERT_IMPLY(a_shared_real, o_v_r && (o_kind_r == qrs_pkg::KIND_DOUBLE || o_kind_r == qrs_pkg::KIND_COMPLEX), o_r1_r == o_r2_r)
  // a blocked numerator stage keeps its item
  `QRS_ASSERT_NEXT(a_p_hold, p_v_r && !p_adv, p_v_r)
endmodule
`default_nettype wire
